[rtl/core/cspl_pkg.sv]
package cspl_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned FracBits    = 16;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DeltaW = DataW + 1;
  localparam int unsigned AccW   = 36;
  localparam int unsigned AccLimLog = 34;
  localparam int unsigned SplitW = 18;
  localparam int unsigned MulAW  = AccW - SplitW + 1;
  localparam int unsigned MulPW  = MulAW + DeltaW;
  localparam int unsigned ProdW  = MulPW + SplitW;
  localparam int unsigned SumW   = AccW + 1;

  localparam int unsigned SegW   = $clog2(MaxSegments);
  localparam int unsigned BrkAw  = $clog2(MaxSegments + 1);
  localparam int unsigned CoefAw = $clog2(4 * MaxSegments);
  localparam int unsigned CntW   = 5;

  typedef enum logic [1:0] {
    FuncWrBreak = 2'd0,
    FuncWrCoeff = 2'd1,
    FuncEval    = 2'd2
  } func_e;

  localparam logic CfgSelSegCount = 1'b0;

  typedef struct packed {
    logic load_a;
    logic mul_lo;
    logic mul_hi;
    logic floor_en;
    logic add_en;
    logic last;
  } cspl_hctl_t;

endpackage

[rtl/core/cspl_horner.sv]
module cspl_horner import cspl_pkg::*; (
  input  logic                     clk_i,
  input  cspl_hctl_t               ctrl_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic signed [DataW-1:0]  coeff_i,
  output logic signed [DataW-1:0]  value_o,
  output logic                     sat_o
);

  localparam logic signed [ProdW-1:0] ProdLimP = ProdW'(1) <<< AccLimLog;
  localparam logic signed [ProdW-1:0] ProdLimN = -ProdLimP;
  localparam logic signed [SumW-1:0]  SumLimP  = SumW'(1) <<< AccLimLog;
  localparam logic signed [SumW-1:0]  SumLimN  = -SumLimP;
  localparam logic signed [SumW-1:0]  OutMaxP  = SumW'((64'd1 << (DataW - 1)) - 64'd1);
  localparam logic signed [SumW-1:0]  OutMinN  = -(SumW'(64'd1 << (DataW - 1)));

  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulPW-1:0] mul_p;
  logic signed [MulPW-1:0] plo_q, phi_q;
  logic signed [ProdW-1:0] prod_full, prod_flr;
  logic signed [AccW-1:0]  mf_q, mf_d;
  logic signed [SumW-1:0]  sum;

  assign mul_a = ctrl_i.mul_hi ? {acc_q[AccW-1], acc_q[AccW-1:SplitW]}
                               : {1'b0, acc_q[SplitW-1:0]};
  assign mul_p = mul_a * delta_i;

  assign prod_full = $signed({phi_q, {SplitW{1'b0}}})
                   + $signed({{SplitW{plo_q[MulPW-1]}}, plo_q});
  assign prod_flr  = prod_full >>> FracBits;

  always_comb begin
    if (prod_flr > ProdLimP) begin
      mf_d = ProdLimP[AccW-1:0];
    end else if (prod_flr < ProdLimN) begin
      mf_d = ProdLimN[AccW-1:0];
    end else begin
      mf_d = prod_flr[AccW-1:0];
    end
  end

  assign sum = $signed({mf_q[AccW-1], mf_q})
             + $signed({{(SumW-DataW){coeff_i[DataW-1]}}, coeff_i});

  always_comb begin
    if (sum > SumLimP) begin
      acc_d = SumLimP[AccW-1:0];
    end else if (sum < SumLimN) begin
      acc_d = SumLimN[AccW-1:0];
    end else begin
      acc_d = sum[AccW-1:0];
    end
  end

  always_comb begin
    if (sum > OutMaxP) begin
      value_o = OutMaxP[DataW-1:0];
      sat_o   = 1'b1;
    end else if (sum < OutMinN) begin
      value_o = OutMinN[DataW-1:0];
      sat_o   = 1'b1;
    end else begin
      value_o = sum[DataW-1:0];
      sat_o   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_a) begin
      acc_q <= {{(AccW-DataW){coeff_i[DataW-1]}}, coeff_i};
    end else if (ctrl_i.add_en && !ctrl_i.last) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.mul_lo) begin
      plo_q <= mul_p;
    end
    if (ctrl_i.mul_hi) begin
      phi_q <= mul_p;
    end
    if (ctrl_i.floor_en) begin
      mf_q <= mf_d;
    end
  end

endmodule

[rtl/core/cubic_spline_eval_unit.sv]
// Piecewise cubic spline evaluator, signed Q16.16.
// Items enter on start and are taken at a clock edge where start is high
// and busy is low. A breakpoint or coefficient write is done at the accepting
// edge and gives no result, so writes can follow each other in every cycle.
// An evaluate beat searches the breakpoint memory one entry per cycle and
// then runs three Horner steps on a shared 19 x 33 multiplier, each through
// the states StMulLo, StMulHi, StFloor and StAdd. The result appears on
// spline_value_o, segment_used_o and saturated_o, marked by done_o, which is
// high for a single cycle. busy is high from the accepting edge until the
// result shows, so one evaluation runs at a time; the next item is taken in
// the cycle that shows the result. The receiver cannot stall the result.
// The segment count register sits at APB address 0; pready is always high.
// Reset sets the segment count to 1 and returns the sequencer to idle. The
// tables are not cleared and must be written before they are read.
module cubic_spline_eval_unit import cspl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              func_i,
  input  logic [5:0]              table_index_i,
  input  logic signed [DataW-1:0] write_value_i,
  input  logic signed [DataW-1:0] x_in_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] spline_value_o,
  output logic [SegW-1:0]         segment_used_o,
  output logic                    saturated_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StSrch  = 8'b0000_0010,
    StBase  = 8'b0000_0100,
    StLoadA = 8'b0000_1000,
    StMulLo = 8'b0001_0000,
    StMulHi = 8'b0010_0000,
    StFloor = 8'b0100_0000,
    StAdd   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]         seg_cnt_q;
  logic [CntW-1:0]         seg_n;
  logic [SegW-1:0]         n_m1_q;
  logic [SegW-1:0]         seg_q, seg_d;
  logic [1:0]              k_q, k_d;
  logic signed [DataW-1:0] x_q;
  logic signed [DeltaW-1:0] d_q;

  logic signed [DataW-1:0] brk_mem [MaxSegments+1];
  logic signed [DataW-1:0] coef_mem [4*MaxSegments];
  logic signed [DataW-1:0] brk_rd_q, coef_rd_q;
  logic                    brk_we, coef_we, brk_re, coef_re;
  logic [BrkAw-1:0]        brk_ra;
  logic [CoefAw-1:0]       coef_ra;

  logic       take, take_eval, found, cfg_we;
  cspl_hctl_t hctl;
  logic signed [DataW-1:0] h_value;
  logic       h_sat;
  logic       done_q, res_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == CfgSelSegCount);
  assign prdata = (paddr[2] == CfgSelSegCount) ? {{(32-CntW){1'b0}}, seg_cnt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= CntW'(1);
    end else if (cfg_we) begin
      seg_cnt_q <= pwdata[CntW-1:0];
    end
  end

  always_comb begin
    if (seg_cnt_q == '0) begin
      seg_n = CntW'(1);
    end else if (seg_cnt_q > CntW'(MaxSegments)) begin
      seg_n = CntW'(MaxSegments);
    end else begin
      seg_n = seg_cnt_q;
    end
  end

  assign busy      = (state_q != StIdle);
  assign take      = start && !busy;
  assign take_eval = take && (func_i == FuncEval);
  assign brk_we    = take && (func_i == FuncWrBreak) && (table_index_i <= 6'(MaxSegments));
  assign coef_we   = take && (func_i == FuncWrCoeff)
                     && ({1'b0, table_index_i} < 7'(4 * MaxSegments));
  assign found     = (x_q <= brk_rd_q) || (seg_q == n_m1_q);

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    k_d     = k_q;
    brk_re  = 1'b0;
    brk_ra  = BrkAw'(1);
    coef_re = 1'b0;
    coef_ra = {seg_q, 2'd0};
    res_we  = 1'b0;
    hctl    = '0;
    unique case (state_q)
      StIdle: begin
        if (take_eval) begin
          brk_re  = 1'b1;
          seg_d   = '0;
          state_d = StSrch;
        end
      end
      StSrch: begin
        brk_re = 1'b1;
        if (found) begin
          brk_ra  = BrkAw'(seg_q);
          state_d = StBase;
        end else begin
          brk_ra  = BrkAw'(seg_q) + BrkAw'(2);
          seg_d   = seg_q + SegW'(1);
        end
      end
      StBase: begin
        coef_re = 1'b1;
        state_d = StLoadA;
      end
      StLoadA: begin
        hctl.load_a = 1'b1;
        coef_re     = 1'b1;
        coef_ra     = {seg_q, 2'd1};
        k_d         = 2'd1;
        state_d     = StMulLo;
      end
      StMulLo: begin
        hctl.mul_lo = 1'b1;
        state_d     = StMulHi;
      end
      StMulHi: begin
        hctl.mul_hi = 1'b1;
        state_d     = StFloor;
      end
      StFloor: begin
        hctl.floor_en = 1'b1;
        state_d       = StAdd;
      end
      StAdd: begin
        hctl.add_en = 1'b1;
        hctl.last   = (k_q == 2'd3);
        if (k_q == 2'd3) begin
          res_we  = 1'b1;
          state_d = StIdle;
        end else begin
          coef_re = 1'b1;
          coef_ra = {seg_q, k_q + 2'd1};
          k_d     = k_q + 2'd1;
          state_d = StMulLo;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= res_we;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    k_q   <= k_d;
    if (take_eval) begin
      x_q    <= x_in_i;
      n_m1_q <= SegW'(seg_n - CntW'(1));
    end
    if (state_q == StBase) begin
      d_q <= {x_q[DataW-1], x_q} - {brk_rd_q[DataW-1], brk_rd_q};
    end
    if (res_we) begin
      spline_value_o <= h_value;
      saturated_o    <= h_sat;
      segment_used_o <= seg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (brk_we) begin
      brk_mem[table_index_i[BrkAw-1:0]] <= write_value_i;
    end
    if (brk_re) begin
      brk_rd_q <= brk_mem[brk_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[table_index_i[CoefAw-1:0]] <= write_value_i;
    end
    if (coef_re) begin
      coef_rd_q <= coef_mem[coef_ra];
    end
  end

  cspl_horner u_horner (
    .clk_i   (clk_i),
    .ctrl_i  (hctl),
    .delta_i (d_q),
    .coeff_i (coef_rd_q),
    .value_o (h_value),
    .sat_o   (h_sat)
  );

  assign done_o = done_q;

  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == StAdd && k_q == 2'd3))
    else $error("Result strobe without a finished Horner pass.");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSrch) |-> (seg_q <= n_m1_q))
    else $error("Segment search ran past the last segment.");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (spline_value_o == 32'sh7fff_ffff || spline_value_o == 32'sh8000_0000))
    else $error("Saturation flag set on an unclipped value.");

  a_eval_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_eval |=> busy)
    else $error("Evaluate beat accepted without the sequencer starting.");

endmodule

[dv/tb_cubic_spline_eval_unit.sv]
`timescale 1ns / 1ps

module tb_cubic_spline_eval_unit import cspl_pkg::*; ();

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned MaxReports  = 10;
  localparam logic [1:0]  FuncIgnored = 2'd3;
  localparam logic [2:0]  SegCountAddr = {CfgSelSegCount, 2'b00};
  localparam longint      AccLim = longint'(1) << AccLimLog;
  localparam longint      QMax = 64'sd2147483647;
  localparam longint      QMin = -64'sd2147483648;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic [SegW-1:0]         seg;
    logic                    sat;
  } spline_res_t;

  class spline_scoreboard;
    logic signed [DataW-1:0] brk [MaxSegments+1];
    logic signed [DataW-1:0] coef [4*MaxSegments];
    logic [CntW-1:0]         seg_cnt;
    spline_res_t             pending [$];
    int unsigned             errors;

    function new();
      seg_cnt = 1;
      errors  = 0;
    endfunction

    function int unsigned active_segs();
      int unsigned n;
      n = seg_cnt;
      if (n == 0) n = 1;
      if (n > MaxSegments) n = MaxSegments;
      return n;
    endfunction

    function longint clamp_acc(longint v);
      if (v > AccLim) return AccLim;
      if (v < -AccLim) return -AccLim;
      return v;
    endfunction

    // Floor of acc * d / 2^FracBits, limited to +/-2^AccLimLog as the partial sums are.
    function longint mul_floor(longint acc, longint d);
      logic signed [127:0] wa, wd, wide;
      wa = acc;
      wd = d;
      wide = (wa * wd) >>> FracBits;
      if (wide > AccLim) return AccLim;
      if (wide < -AccLim) return -AccLim;
      return wide[63:0];
    endfunction

    function spline_res_t eval_spline(logic signed [DataW-1:0] x);
      int unsigned n, seg;
      longint xv, d, acc;
      spline_res_t r;
      n   = active_segs();
      xv  = x;
      seg = 0;
      while (seg < n && !(xv <= longint'(brk[seg+1]))) seg++;
      if (seg == n) seg = n - 1;
      d   = xv - longint'(brk[seg]);
      acc = coef[4*seg];
      acc = clamp_acc(mul_floor(acc, d) + longint'(coef[4*seg+1]));
      acc = clamp_acc(mul_floor(acc, d) + longint'(coef[4*seg+2]));
      acc = mul_floor(acc, d) + longint'(coef[4*seg+3]);
      r.sat = 1'b0;
      if (acc > QMax) begin
        acc = QMax;
        r.sat = 1'b1;
      end
      if (acc < QMin) begin
        acc = QMin;
        r.sat = 1'b1;
      end
      r.value = acc[DataW-1:0];
      r.seg   = seg[SegW-1:0];
      return r;
    endfunction

    function void note_input(logic [1:0] fn, logic [5:0] idx, logic signed [DataW-1:0] wv,
                             logic signed [DataW-1:0] xv);
      case (fn)
        FuncWrBreak: if (idx <= MaxSegments) brk[idx] = wv;
        FuncWrCoeff: if (idx < 4 * MaxSegments) coef[idx] = wv;
        FuncEval: pending.push_back(eval_spline(xv));
        default: ;
      endcase
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MaxReports) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic signed [DataW-1:0] value, logic [SegW-1:0] seg,
                               logic sat);
      spline_res_t e;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected beat value=%0d seg=%0d sat=%0b", value, seg, sat));
        return;
      end
      e = pending.pop_front();
      if (e.value !== value || e.seg !== seg || e.sat !== sat) begin
        note_error($sformatf("expected value=%0d seg=%0d sat=%0b, got value=%0d seg=%0d sat=%0b",
                             e.value, e.seg, e.sat, value, seg, sat));
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              func_i;
  logic [5:0]              table_index_i;
  logic signed [DataW-1:0] write_value_i;
  logic signed [DataW-1:0] x_in_i;
  logic                    done_o;
  logic signed [DataW-1:0] spline_value_o;
  logic [SegW-1:0]         segment_used_o;
  logic                    saturated_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  spline_scoreboard sb;
  int unsigned      cycles;

  cubic_spline_eval_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .table_index_i  (table_index_i),
    .write_value_i  (write_value_i),
    .x_in_i         (x_in_i),
    .done_o         (done_o),
    .spline_value_o (spline_value_o),
    .segment_used_o (segment_used_o),
    .saturated_o    (saturated_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(spline_value_o, segment_used_o, saturated_o);
  end

  task automatic send_item(logic [1:0] fn, logic [31:0] idx, logic [31:0] wv, logic [31:0] xv);
    @(negedge clk_i);
    start         = 1'b1;
    func_i        = fn;
    table_index_i = idx[5:0];
    write_value_i = wv;
    x_in_i        = xv;
    do @(posedge clk_i); while (busy);
    sb.note_input(fn, idx[5:0], wv, xv);
  endtask

  task automatic pause_sender(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start = 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 30)) @(negedge clk_i);
      else repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_segment_count(logic [CntW-1:0] cnt);
    logic [31:0] data, want;
    data = $urandom;
    data[CntW-1:0] = cnt;
    want = '0;
    want[CntW-1:0] = cnt;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SegCountAddr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.seg_cnt = cnt;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      sb.note_error($sformatf("segment count read expected %0d, got %0d", want, prdata));
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [31:0] rand_coeff();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1, 2: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Ascending breakpoints with occasional repeats, then a full set of coefficients.
  task automatic fill_tables(int unsigned n, int unsigned pct, bit wide);
    longint b;
    if (wide) b = -longint'($urandom_range(0, 32'h4000_0000));
    else b = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
    for (int unsigned k = 0; k <= n; k++) begin
      pause_sender(pct);
      send_item(FuncWrBreak, k, b[31:0], $urandom);
      if ($urandom_range(7) != 0) begin
        b += $urandom_range(1, wide ? 32'h0400_0000 : 32'h0002_0000);
      end
    end
    for (int unsigned k = 0; k < 4 * n; k++) begin
      pause_sender(pct);
      send_item(FuncWrCoeff, k, rand_coeff(), $urandom);
    end
  endtask

  function automatic logic [31:0] pick_x(int unsigned n);
    int unsigned k;
    longint span, x;
    case ($urandom_range(19))
      0, 1: x = $signed($urandom);
      2: x = QMin;
      3: x = QMax;
      4, 5: x = sb.brk[$urandom_range(n)];
      6: x = longint'(sb.brk[0]) - $urandom_range(1, 32'h0001_0000);
      7: x = longint'(sb.brk[n]) + $urandom_range(1, 32'h0001_0000);
      default: begin
        k = $urandom_range(n - 1);
        span = longint'(sb.brk[k+1]) - longint'(sb.brk[k]);
        x = sb.brk[k];
        if (span > 0) x += $urandom_range(0, span[31:0]);
      end
    endcase
    return x[31:0];
  endfunction

  task automatic random_items(int unsigned n, int unsigned count, int unsigned pct);
    int unsigned r, idx;
    for (int unsigned i = 0; i < count; i++) begin
      pause_sender(pct);
      r = $urandom_range(99);
      if (r < 55) begin
        send_item(FuncEval, $urandom, $urandom, pick_x(n));
      end else if (r < 70) begin
        send_item(FuncWrCoeff, $urandom_range(63), rand_coeff(), $urandom);
      end else if (r < 80) begin
        idx = $urandom_range(n);
        send_item(FuncWrBreak, idx, sb.brk[idx] + $signed($urandom_range(0, 32'h0002_0000))
                  - 32'sh0001_0000, $urandom);
      end else if (r < 90) begin
        send_item(FuncIgnored, $urandom, $urandom, $urandom);
      end else begin
        send_item(FuncWrBreak, $urandom_range(MaxSegments + 1, 63), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [CntW-1:0] seg_counts [8];
    int unsigned n, pct;
    seg_counts = '{5'd16, 5'd0, 5'd31, 5'd4, 5'd1, 5'd17, 5'd9, 5'd16};
    sb            = new();
    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = FuncWrBreak;
    table_index_i = '0;
    write_value_i = '0;
    x_in_i        = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // One segment after reset: a pure cubic on [0, 1], then extreme coefficients.
    send_item(FuncWrBreak, 0, 32'h0000_0000, 32'h0);
    send_item(FuncWrBreak, 1, 32'h0001_0000, 32'h0);
    send_item(FuncWrCoeff, 0, 32'h0001_0000, 32'h0);
    send_item(FuncWrCoeff, 1, 32'h0000_0000, 32'h0);
    send_item(FuncWrCoeff, 2, 32'h0000_0000, 32'h0);
    send_item(FuncWrCoeff, 3, 32'h0000_0000, 32'h0);
    send_item(FuncEval, 0, 32'h0, 32'h0000_8000);
    send_item(FuncEval, 0, 32'h0, 32'hFFFF_8000);
    send_item(FuncEval, 0, 32'h0, 32'h0002_0000);
    send_item(FuncEval, 0, 32'h0, 32'h0001_0000);
    send_item(FuncEval, 0, 32'h0, 32'h7FFF_FFFF);
    send_item(FuncEval, 0, 32'h0, 32'h8000_0000);
    send_item(FuncWrBreak, 17, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(FuncWrBreak, 63, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(FuncIgnored, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FuncWrCoeff, 0, 32'h8000_0000, 32'h0);
    send_item(FuncWrCoeff, 1, 32'h7FFF_FFFF, 32'h0);
    send_item(FuncWrCoeff, 2, 32'h8000_0000, 32'h0);
    send_item(FuncWrCoeff, 3, 32'h7FFF_FFFF, 32'h0);
    send_item(FuncEval, 63, 32'h0, 32'h7FFF_FFFF);
    send_item(FuncEval, 63, 32'h0, 32'h8000_0000);
    send_item(FuncEval, 0, 32'h0, 32'h0000_0000);
    send_item(FuncWrCoeff, 63, 32'hFFFF_FFFF, 32'h0);
    drain();

    for (int unsigned p = 0; p < 8; p++) begin
      set_segment_count(seg_counts[p]);
      n   = sb.active_segs();
      pct = (p == 3) ? 0 : 20;
      fill_tables(n, pct, p[0]);
      random_items(n, 150, pct);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/cspl_pkg.sv
rtl/core/cspl_horner.sv
rtl/core/cubic_spline_eval_unit.sv
dv/tb_cubic_spline_eval_unit.sv
